@@ rtl/core/stp_pkg.sv @@
// Package with the types, constants and codes shared by the timer pool files.
package stp_pkg;

  // Pool size and the largest number of expiries reported by one tick.
  localparam int NumSlots = 16;
  localparam int MaxRun   = 16;

  // Width of a walk position and of the expiry run counter.
  localparam int SlotIdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int RunW     = $clog2(MaxRun + 1);

  // Operation codes of an input item; the two remaining codes are unknown.
  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_CREATE  = 3'd1,
    KIND_LAUNCH  = 3'd2,
    KIND_QUERY   = 3'd3,
    KIND_ABORT   = 3'd4,
    KIND_DESTROY = 3'd5
  } kind_e;

  // Result kinds.
  typedef enum logic {
    RES_STATUS = 1'b0,
    RES_EXPIRY = 1'b1
  } res_kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  // One input item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [15:0] wait_ticks;
    logic [7:0]  callback_id;
    logic [31:0] pointer_tag;
    logic [31:0] param_word;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        result_kind;
    logic [3:0]  slot_out;
    logic        ok;
    logic        armed_out;
    logic [7:0]  callback_out;
    logic [31:0] pointer_out;
    logic [31:0] param_out;
    logic        end_of_run;
  } result_t;

  // State of one timeout slot, held in one cell of the ring.
  typedef struct packed {
    logic        assigned;
    logic        armed;
    logic [15:0] count;
    logic [7:0]  callback;
    logic [31:0] pointer;
    logic [31:0] param;
  } slot_rec_t;

  // What the sequencer hands to the ring in each cycle.
  typedef struct packed {
    logic      shift;
    slot_rec_t rec;
  } ring_ctl_t;

endpackage

@@ rtl/core/stp_cell.sv @@
// One cell of the slot ring: holds one slot record and takes its neighbor's on a shift.
module stp_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  stp_pkg::slot_rec_t d_i,
  output stp_pkg::slot_rec_t q_o
);
  import stp_pkg::*;

  logic        assigned_q;
  logic        armed_q;
  logic [15:0] count_q;
  logic [7:0]  callback_q;
  logic [31:0] pointer_q;
  logic [31:0] param_q;

  // Flags are cleared by reset; the rest of the record is defined by a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assigned_q <= 1'b0;
      armed_q    <= 1'b0;
    end else if (shift_i) begin
      assigned_q <= d_i.assigned;
      armed_q    <= d_i.armed;
    end
  end

  // Payload fields carry no reset.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      count_q    <= d_i.count;
      callback_q <= d_i.callback;
      pointer_q  <= d_i.pointer;
      param_q    <= d_i.param;
    end
  end

  assign q_o = '{assigned_q, armed_q, count_q, callback_q, pointer_q, param_q};

endmodule

@@ rtl/core/stp_ctrl.sv @@
// Sequencer and head processing unit of the slot ring, with the result register.
module stp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  stp_pkg::item_t     item_i,
  output logic               busy,
  input  stp_pkg::slot_rec_t head_i,
  output stp_pkg::ring_ctl_t ring_o,
  output logic               result_valid_o,
  output stp_pkg::result_t   result_o
);
  import stp_pkg::*;

  localparam int CmpW = (SlotIdxW > 4) ? SlotIdxW : 4;
  localparam logic [SlotIdxW-1:0] LastStep = SlotIdxW'(NumSlots - 1);

  state_e              state_q, state_d;
  logic [SlotIdxW-1:0] step_q, step_d;
  item_t               item_q, item_d;
  logic [RunW-1:0]     run_q, run_d;
  logic                found_q, found_d;
  logic [3:0]          rep_slot_q, rep_slot_d;
  logic                rep_ok_q, rep_ok_d;
  logic                rep_armed_q, rep_armed_d;
  logic                pend_q, pend_d;
  result_t             pend_res_q, pend_res_d;
  logic                res_valid_q, res_valid_d;
  result_t             res_q, res_d;

  logic                accept;
  logic [CmpW-1:0]     step_ext;
  logic [CmpW-1:0]     slot_ext;
  logic                at_slot;
  slot_rec_t           rec_new;
  result_t             expiry;

  assign accept   = start && (state_q == ST_IDLE);
  assign step_ext = CmpW'(step_q);
  assign slot_ext = CmpW'(item_q.slot);
  assign at_slot  = (step_ext == slot_ext);

  // Next state: a full walk of the ring, then the flush state that delivers the last result.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_WALK;
      ST_WALK:  if (step_q == LastStep) state_d = ST_FLUSH;
      ST_FLUSH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Expiry record built from the slot at the head of the ring.
  always_comb begin
    expiry              = '0;
    expiry.result_kind  = RES_EXPIRY;
    expiry.slot_out     = step_ext[3:0];
    expiry.ok           = 1'b1;
    expiry.callback_out = head_i.callback;
    expiry.pointer_out  = head_i.pointer;
    expiry.param_out    = head_i.param;
  end

  // Head processing, reply bookkeeping and result selection.
  always_comb begin
    step_d      = step_q;
    item_d      = item_q;
    run_d       = run_q;
    found_d     = found_q;
    rep_slot_d  = rep_slot_q;
    rep_ok_d    = rep_ok_q;
    rep_armed_d = rep_armed_q;
    pend_d      = pend_q;
    pend_res_d  = pend_res_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rec_new     = head_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d      = item_i;
          step_d      = '0;
          run_d       = '0;
          found_d     = 1'b0;
          rep_slot_d  = (kind_e'(item_i.kind) == KIND_CREATE) ? 4'd0 : item_i.slot;
          rep_ok_d    = 1'b0;
          rep_armed_d = 1'b0;
          pend_d      = 1'b0;
        end
      end

      ST_WALK: begin
        step_d = step_q + SlotIdxW'(1);
        case (item_q.kind)
          KIND_TICK: begin
            if (head_i.armed && head_i.assigned) begin
              if (head_i.count == 16'd0) begin
                if (run_q < RunW'(MaxRun)) begin
                  rec_new.armed = 1'b0;
                  run_d         = run_q + RunW'(1);
                  pend_d        = 1'b1;
                  pend_res_d    = expiry;
                  if (pend_q) begin
                    res_valid_d = 1'b1;
                    res_d       = pend_res_q;
                  end
                end
              end else begin
                rec_new.count = head_i.count - 16'd1;
              end
            end
          end
          KIND_CREATE: begin
            if (item_q.callback_id != 8'd0 && !found_q && !head_i.assigned) begin
              rec_new.assigned = 1'b1;
              rec_new.callback = item_q.callback_id;
              rec_new.pointer  = '0;
              rec_new.param    = '0;
              found_d          = 1'b1;
              rep_slot_d       = step_ext[3:0];
              rep_ok_d         = 1'b1;
            end
          end
          KIND_LAUNCH: begin
            if (at_slot && head_i.assigned && item_q.wait_ticks != 16'd0) begin
              rec_new.count   = item_q.wait_ticks;
              rec_new.pointer = item_q.pointer_tag;
              rec_new.param   = item_q.param_word;
              rec_new.armed   = 1'b1;
              rep_ok_d        = 1'b1;
            end
          end
          KIND_QUERY: begin
            if (at_slot) begin
              rep_ok_d    = head_i.assigned;
              rep_armed_d = head_i.assigned && head_i.armed;
            end
          end
          KIND_ABORT: begin
            if (at_slot && head_i.assigned) begin
              rec_new.armed = 1'b0;
              rep_ok_d      = 1'b1;
            end
          end
          KIND_DESTROY: begin
            if (at_slot && head_i.assigned) begin
              rec_new.armed    = 1'b0;
              rec_new.assigned = 1'b0;
              rep_ok_d         = 1'b1;
            end
          end
          default: ;
        endcase
      end

      ST_FLUSH: begin
        pend_d = 1'b0;
        if (kind_e'(item_q.kind) == KIND_TICK) begin
          if (pend_q) begin
            res_valid_d      = 1'b1;
            res_d            = pend_res_q;
            res_d.end_of_run = 1'b1;
          end
        end else begin
          res_valid_d       = 1'b1;
          res_d             = '0;
          res_d.result_kind = RES_STATUS;
          res_d.slot_out    = rep_slot_q;
          res_d.ok          = rep_ok_q;
          res_d.armed_out   = rep_armed_q;
          res_d.end_of_run  = 1'b1;
        end
      end

      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      run_q       <= '0;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      run_q       <= run_d;
      found_q     <= found_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    rep_slot_q  <= rep_slot_d;
    rep_ok_q    <= rep_ok_d;
    rep_armed_q <= rep_armed_d;
    pend_res_q  <= pend_res_d;
    res_q       <= res_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign ring_o.shift   = (state_q == ST_WALK);
  assign ring_o.rec     = rec_new;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // A transfer that was taken starts a walk.
  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_WALK)
    else $error("accepted item did not start a walk");

  // The walk ends after the last ring position.
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && step_q == LastStep) |=> state_q == ST_FLUSH)
    else $error("walk overran the ring");

  // A held expiry exists only while an item is in work.
  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_WALK || state_q == ST_FLUSH))
    else $error("held expiry outside a walk");

  // Only an expiry can be followed by more results of the same item.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.end_of_run) |-> res_q.result_kind == RES_EXPIRY)
    else $error("status reply not marked as last");

endmodule

@@ rtl/core/software_timer_pool.sv @@
// Top level of the timeout slot pool: a ring of slot cells and its sequencer.
//
//   channel   handshake                 payload
//   input     start / busy              item_i   (stp_pkg::item_t)
//   result    result_valid_o (strobe)   result_o (stp_pkg::result_t)
//
// Every item rotates the slot records once around the ring of cells past the single
// processing unit at its head, then the flush state delivers the last result.
// Expiries of a tick appear during the walk, each one delayed by one found expiry so
// that the last can be marked end_of_run.
// Reset clears the assigned and armed flags of every cell and the sequencer.
// busy is high for the whole walk; results are strobes the receiver cannot stall.
module software_timer_pool (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  stp_pkg::item_t   item_i,
  output logic             busy,
  output logic             result_valid_o,
  output stp_pkg::result_t result_o
);
  import stp_pkg::*;

  slot_rec_t rec[NumSlots];
  ring_ctl_t ring;

  // Sequencer with the processing unit at the ring head.
  stp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (item_i),
    .busy           (busy),
    .head_i         (rec[0]),
    .ring_o         (ring),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Ring of cells: each takes its upper neighbor; the last takes the processed head.
  for (genvar i = 0; i < NumSlots; i++) begin : g_cell
    slot_rec_t d;
    if (i == NumSlots - 1) begin : g_tail
      assign d = ring.rec;
    end else begin : g_link
      assign d = rec[i+1];
    end
    stp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring.shift),
      .d_i     (d),
      .q_o     (rec[i])
    );
  end

endmodule

@@ bench/timer_pool_checker.sv @@
// Checker for the timeout slot pool: predicts replies and expiries and compares them.
module timer_pool_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  stp_pkg::item_t   item_i,
  input  logic             res_valid_i,
  input  stp_pkg::result_t res_i,
  output int               err_cnt_o,
  output int               pending_o
);
  import stp_pkg::*;

  // Predicted pool state.
  logic [NumSlots-1:0] slot_assigned;
  logic [NumSlots-1:0] slot_armed;
  logic [15:0]         slot_count [NumSlots];
  logic [7:0]          slot_cb    [NumSlots];
  logic [31:0]         slot_ptr   [NumSlots];
  logic [31:0]         slot_par   [NumSlots];

  // Replies and expiries still owed by the block, oldest first.
  result_t outcome_q[$];

  initial err_cnt_o = 0;

  // Updates the predicted pool for one accepted operation and queues what it owes.
  task automatic model_timer_op(input item_t op);
    result_t reply;
    result_t run [MaxRun];
    logic    valid;
    int      n;
    reply = '0;
    reply.result_kind = RES_STATUS;
    reply.slot_out = op.slot;
    reply.end_of_run = 1'b1;
    valid = (int'(op.slot) < NumSlots) && slot_assigned[op.slot];
    n = 0;
    case (op.kind)
      KIND_TICK: begin
        // Walk the slots in order; due slots expire, the others count down.
        for (int i = 0; i < NumSlots; i++) begin
          if (slot_armed[i] && slot_assigned[i]) begin
            if (slot_count[i] == 16'd0) begin
              if (n < MaxRun) begin
                slot_armed[i] = 1'b0;
                run[n] = '0;
                run[n].result_kind = RES_EXPIRY;
                run[n].slot_out = 4'(i);
                run[n].ok = 1'b1;
                run[n].callback_out = slot_cb[i];
                run[n].pointer_out = slot_ptr[i];
                run[n].param_out = slot_par[i];
                n++;
              end
            end else begin
              slot_count[i] = slot_count[i] - 16'd1;
            end
          end
        end
        // Only the last expiry of the run carries the end marker.
        for (int i = 0; i < n; i++) begin
          run[i].end_of_run = (i == n - 1);
          outcome_q.push_back(run[i]);
        end
      end
      KIND_CREATE: begin
        // Claim the lowest free slot; a zero callback or a full pool fails.
        reply.slot_out = '0;
        if (op.callback_id != 8'd0) begin
          for (int i = 0; i < NumSlots; i++) begin
            if (!reply.ok && !slot_assigned[i]) begin
              slot_assigned[i] = 1'b1;
              slot_cb[i] = op.callback_id;
              slot_ptr[i] = '0;
              slot_par[i] = '0;
              reply.slot_out = 4'(i);
              reply.ok = 1'b1;
            end
          end
        end
        outcome_q.push_back(reply);
      end
      KIND_LAUNCH: begin
        reply.ok = valid && (op.wait_ticks != 16'd0);
        if (reply.ok) begin
          slot_count[op.slot] = op.wait_ticks;
          slot_ptr[op.slot] = op.pointer_tag;
          slot_par[op.slot] = op.param_word;
          slot_armed[op.slot] = 1'b1;
        end
        outcome_q.push_back(reply);
      end
      KIND_QUERY: begin
        reply.ok = valid;
        reply.armed_out = valid && slot_armed[op.slot];
        outcome_q.push_back(reply);
      end
      KIND_ABORT: begin
        reply.ok = valid;
        if (valid) slot_armed[op.slot] = 1'b0;
        outcome_q.push_back(reply);
      end
      KIND_DESTROY: begin
        reply.ok = valid;
        if (valid) begin
          slot_armed[op.slot] = 1'b0;
          slot_assigned[op.slot] = 1'b0;
        end
        outcome_q.push_back(reply);
      end
      default: begin
        // Unknown operations answer with a failed reply and change nothing.
        outcome_q.push_back(reply);
      end
    endcase
  endtask

  function automatic string fmt_result(input result_t r);
    return $sformatf("kind %0d slot %0d ok %0d armed %0d cb %h ptr %h par %h end %0d",
                     r.result_kind, r.slot_out, r.ok, r.armed_out, r.callback_out,
                     r.pointer_out, r.param_out, r.end_of_run);
  endfunction

  // Input transfers are predicted before result transfers of the same edge are checked.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      slot_assigned = '0;
      slot_armed = '0;
      outcome_q.delete();
      pending_o = 0;
    end else begin
      if (start_i && !busy_i) model_timer_op(item_i);
      if (res_valid_i) begin
        if (outcome_q.size() == 0) begin
          err_cnt_o++;
          $display("%0t: result with nothing expected: expected none, actual %s",
                   $time, fmt_result(res_i));
        end else begin
          want = outcome_q.pop_front();
          if (res_i !== want) begin
            err_cnt_o++;
            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                     $time, fmt_result(want), fmt_result(res_i));
          end
        end
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the timeout slot pool: clock, reset, stimulus and verdict.
module tb_top;
  import stp_pkg::*;

  // The two operation codes the block does not define.
  localparam logic [2:0] KindSpare6 = 3'd6;
  localparam logic [2:0] KindSpare7 = 3'd7;

  // Upper bound on the run length in clock cycles.
  localparam int CycleLimit = 200000;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  item_t   item_i;
  logic    busy;
  logic    result_valid_o;
  result_t result_o;
  int      err_cnt;
  int      pending;
  int      gap_pct;
  int      cycle_cnt;

  software_timer_pool i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (item_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  timer_pool_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item_i),
    .res_valid_i (result_valid_o),
    .res_i       (result_o),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  // Clock with a period of 12.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Offers one operation after a random gap and returns at the edge of its transfer.
  // start stays high afterwards so that back-to-back operations need no extra step.
  task automatic send_op(input item_t op);
    int gap;
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= op;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic issue(input logic [2:0] kind, input logic [3:0] slot,
                       input logic [15:0] wait_ticks, input logic [7:0] callback_id,
                       input logic [31:0] pointer_tag, input logic [31:0] param_word);
    item_t op;
    op = '{kind, slot, wait_ticks, callback_id, pointer_tag, param_word};
    send_op(op);
  endtask

  // Holds off new operations until every owed result has arrived and the block is idle.
  task automatic drain_pool();
    start <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (pending == 0 && !busy) break;
    end
    @(posedge clk_i);
  endtask

  // Random operation, weighted toward short waits and ticks so that timers expire often.
  function automatic item_t random_op();
    item_t op;
    int    pick;
    int    w;
    pick = $urandom_range(99);
    w = $urandom_range(9);
    op.slot = $urandom_range(1) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
    op.wait_ticks = (w == 0) ? 16'd0 : (w == 1) ? 16'($urandom) : 16'($urandom_range(4, 1));
    op.callback_id = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255));
    op.pointer_tag = $urandom;
    op.param_word = $urandom;
    if (pick < 30)      op.kind = KIND_TICK;
    else if (pick < 50) op.kind = KIND_CREATE;
    else if (pick < 77) op.kind = KIND_LAUNCH;
    else if (pick < 87) op.kind = KIND_QUERY;
    else if (pick < 92) op.kind = KIND_ABORT;
    else if (pick < 98) op.kind = KIND_DESTROY;
    else                op.kind = $urandom_range(1) ? KindSpare6 : KindSpare7;
    return op;
  endfunction

  // Run watchdog.
  initial begin
    for (cycle_cnt = 0; cycle_cnt < CycleLimit; cycle_cnt++) @(posedge clk_i);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    gap_pct = 24;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty pool, failed and granted creates, launch corner cases,
    // relaunch, expiry timing, unknown operations, and reuse of a freed slot.
    issue(KIND_TICK, 4'd0, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KIND_QUERY, 4'd0, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KIND_LAUNCH, 4'd3, 16'd5, 8'd0, 32'd1, 32'd2);
    issue(KIND_ABORT, 4'd15, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KIND_DESTROY, 4'd15, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KIND_CREATE, 4'd0, 16'd0, 8'h00, 32'd0, 32'd0);
    issue(KIND_CREATE, 4'd9, 16'd0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(KIND_CREATE, 4'd0, 16'd0, 8'h01, 32'd0, 32'd0);
    issue(KIND_LAUNCH, 4'd0, 16'd0, 8'd0, 32'h1234_5678, 32'h9ABC_DEF0);
    issue(KIND_LAUNCH, 4'd0, 16'd1, 8'd0, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(KIND_LAUNCH, 4'd1, 16'hFFFF, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(KIND_QUERY, 4'd0, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KIND_QUERY, 4'd1, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KIND_LAUNCH, 4'd1, 16'd2, 8'd0, 32'hA5A5_5A5A, 32'h0123_4567);
    issue(KIND_TICK, 4'd0, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KIND_TICK, 4'd0, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KIND_TICK, 4'd0, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KindSpare6, 4'd2, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(KindSpare7, 4'd15, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KIND_ABORT, 4'd0, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KIND_DESTROY, 4'd1, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KIND_QUERY, 4'd1, 16'd0, 8'd0, 32'd0, 32'd0);
    issue(KIND_CREATE, 4'd0, 16'd0, 8'h02, 32'd0, 32'd0);

    // Random part in three stretches of sender gaps, with full drains in between.
    for (int n = 0; n < 66; n++) send_op(random_op());
    drain_pool();
    gap_pct = 66;
    for (int n = 0; n < 66; n++) send_op(random_op());
    drain_pool();
    gap_pct = 0;
    for (int n = 0; n < 65; n++) send_op(random_op());
    drain_pool();
    repeat (40) @(posedge clk_i);

    if (err_cnt == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
